[design/transposition_table_store_core_macros.svh]
// ----------------------------------------------------------------------------
// transposition_table_store_core_macros.svh
// Assertion macros shared by the table store checker.
// ----------------------------------------------------------------------------
`ifndef TRANSPOSITION_TABLE_STORE_CORE_MACROS_SVH
`define TRANSPOSITION_TABLE_STORE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while in reset
`define TTS_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("table store check failed");

// Next-cycle implication, sampled on clk_i, off while in reset
`define TTS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("table store check failed");

`endif

[design/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types and fixed constants of the transposition table store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tts_pkg;

  localparam int unsigned KEY_W       = 64;
  localparam int unsigned MIN_ENTRIES = 256;
  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned CFG_DATA_W  = 13;

  // Operation codes
  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_FIND  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_ENTRIES    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXACT_CODE       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOWER_BOUND_CODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_UPPER_BOUND_CODE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_USE_OLD_MOVES    = 3'd4;

  // One input item
  typedef struct packed {
    logic               op;
    logic [63:0]        hash_key;
    logic signed [15:0] entry_score;
    logic [7:0]         search_depth;
    logic [2:0]         node_code;
    logic [15:0]        move_word;
    logic [14:0]        search_age;
    logic signed [15:0] alpha_in;
    logic signed [15:0] beta_in;
  } in_item_t;

  // One result item
  typedef struct packed {
    logic [15:0]        hit_move;
    logic signed [15:0] score_out;
    logic               score_set;
    logic signed [15:0] alpha_out;
    logic signed [15:0] beta_out;
  } res_item_t;

  // Stored entry data besides the key
  typedef struct packed {
    logic [14:0]        age;
    logic [15:0]        move;
    logic [2:0]         node;
    logic [7:0]         depth;
    logic signed [15:0] score;
  } info_t;

  // Status of the remainder unit
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

[design/transposition_table_store_core.sv]
// ----------------------------------------------------------------------------
// transposition_table_store_core
// Direct-mapped search-result table with place and find items.
// ----------------------------------------------------------------------------
// An item is taken when start_i is high and busy_o is low, and busy_o then
// stays high while the remainder unit, loaded at the accepting edge, runs its
// one-bit-per-step key modulo slot count over the whole key; then the slot
// register loads the unit's result, the memory is read, and the entry is
// evaluated and written back. The next item can be taken at the end of the
// first cycle with busy_o low, so a new item is never taken while one is in
// progress. A find gives its result on res_o with res_valid_o high for exactly
// one cycle, in the cycle busy_o is low again; the receiver cannot stall it,
// so it must take it then. A place gives no result. After reset and after
// every write of table_entries the table is swept to zero with busy_o high;
// configuration writes are taken at any time (cfg_ready_o stays high).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module transposition_table_store_core #(
  parameter int unsigned MAX_ENTRIES = 4096
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire tts_pkg::in_item_t                 item_i,
  output logic                                   busy_o,
  output logic                                   res_valid_o,
  output tts_pkg::res_item_t                     res_o,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tts_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [tts_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  localparam int unsigned IDX_W = $clog2(MAX_ENTRIES);
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_DIV   = 5'b00100,
    S_READ  = 5'b01000,
    S_EVAL  = 5'b10000
  } state_e;

  state_e                state_q, state_d;
  logic [IDX_W-1:0]      clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0]      slot_q, slot_d;
  tts_pkg::in_item_t     item_q;
  logic [CNT_W-1:0]      entries_q;
  logic [2:0]            exact_code_q, lower_code_q, upper_code_q;
  logic                  use_old_q;
  logic                  res_valid_q, res_valid_d;
  tts_pkg::res_item_t    res_q, res_d;

  logic                  accept;
  logic                  cfg_wr;
  logic                  clr_start;
  logic [31:0]           cfg_ent;
  logic [CNT_W-1:0]      ent_clamped;

  tts_pkg::div_stat_t    div_stat;
  logic [IDX_W-1:0]      div_rem;

  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [tts_pkg::KEY_W-1:0] wr_key;
  tts_pkg::info_t        wr_info;
  logic                  rd_en;
  logic [tts_pkg::KEY_W-1:0] rd_key;
  tts_pkg::info_t        rd_info;

  logic                  keep_old;
  logic                  key_hit;

  assign accept      = start_i && (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i && cfg_ready_o;
  assign clr_start   = cfg_wr && (cfg_index_i == tts_pkg::REG_TABLE_ENTRIES);

  // Clamp the slot count into the supported range
  assign cfg_ent = 32'(cfg_data_i);
  always_comb begin
    if (cfg_ent < 32'(tts_pkg::MIN_ENTRIES)) begin
      ent_clamped = CNT_W'(tts_pkg::MIN_ENTRIES);
    end else if (cfg_ent > 32'(MAX_ENTRIES)) begin
      ent_clamped = CNT_W'(MAX_ENTRIES);
    end else begin
      ent_clamped = cfg_ent[CNT_W-1:0];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entries_q    <= CNT_W'(tts_pkg::MIN_ENTRIES);
      exact_code_q <= 3'd0;
      lower_code_q <= 3'd1;
      upper_code_q <= 3'd2;
      use_old_q    <= 1'b0;
    end else if (cfg_wr) begin
      case (cfg_index_i)
        tts_pkg::REG_TABLE_ENTRIES:    entries_q    <= ent_clamped;
        tts_pkg::REG_EXACT_CODE:       exact_code_q <= cfg_data_i[2:0];
        tts_pkg::REG_LOWER_BOUND_CODE: lower_code_q <= cfg_data_i[2:0];
        tts_pkg::REG_UPPER_BOUND_CODE: upper_code_q <= cfg_data_i[2:0];
        tts_pkg::REG_USE_OLD_MOVES:    use_old_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Slot index: key modulo slot count
  tts_mod_div #(
    .CNT_W (CNT_W),
    .IDX_W (IDX_W)
  ) u_mod_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (item_i.hash_key),
    .divisor_i  (entries_q),
    .stat_o     (div_stat),
    .rem_o      (div_rem)
  );

  tts_table_mem #(
    .DEPTH (MAX_ENTRIES),
    .IDX_W (IDX_W)
  ) u_table_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_key_i  (wr_key),
    .wr_info_i (wr_info),
    .rd_en_i   (rd_en),
    .rd_addr_i (slot_q),
    .rd_key_o  (rd_key),
    .rd_info_o (rd_info)
  );

  // Replacement and hit checks on the entry read back
  assign keep_old = (rd_info.age >= item_q.search_age) && (rd_info.node > item_q.node_code);
  assign key_hit  = (rd_key == item_q.hash_key);

  // Sequencer and evaluation
  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    slot_d      = slot_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = slot_q;
    wr_key      = item_q.hash_key;
    wr_info.age   = item_q.search_age;
    wr_info.move  = item_q.move_word;
    wr_info.node  = item_q.node_code;
    wr_info.depth = item_q.search_depth;
    wr_info.score = item_q.entry_score;

    case (state_q)
      S_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        wr_key    = '0;
        wr_info   = '0;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == IDX_W'(MAX_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          slot_d  = div_rem;
          state_d = S_READ;
        end
      end
      S_READ: begin
        rd_en   = 1'b1;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        state_d = S_IDLE;
        if (item_q.op == tts_pkg::OP_PLACE) begin
          wr_en = !keep_old;
        end else begin
          res_valid_d     = 1'b1;
          res_d.hit_move  = '0;
          res_d.score_out = '0;
          res_d.score_set = 1'b0;
          res_d.alpha_out = item_q.alpha_in;
          res_d.beta_out  = item_q.beta_in;
          if (key_hit) begin
            if (rd_info.age == item_q.search_age) begin
              res_d.hit_move = rd_info.move;
              if (rd_info.depth >= item_q.search_depth) begin
                // Exact first, then lower bound, then upper bound
                if (rd_info.node == exact_code_q) begin
                  res_d.score_out = rd_info.score;
                  res_d.score_set = 1'b1;
                end else if (rd_info.node == lower_code_q) begin
                  if (rd_info.score > item_q.alpha_in) begin
                    res_d.alpha_out = rd_info.score;
                  end
                end else if (rd_info.node == upper_code_q) begin
                  if (rd_info.score < item_q.beta_in) begin
                    res_d.beta_out = rd_info.score;
                  end
                end
              end
            end else if (use_old_q) begin
              res_d.hit_move = rd_info.move;
            end
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A table_entries write restarts the sweep
    if (clr_start) begin
      state_d   = S_CLEAR;
      clr_cnt_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_cnt_q   <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
    slot_q <= slot_d;
    res_q  <= res_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

[design/tts_mod_div.sv]
// ----------------------------------------------------------------------------
// tts_mod_div
// Restoring remainder unit: key modulo slot count, one key bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tts_mod_div #(
  parameter int unsigned CNT_W = 13,
  parameter int unsigned IDX_W = 12
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [tts_pkg::KEY_W-1:0]   dividend_i,
  input  wire logic [CNT_W-1:0]            divisor_i,
  output tts_pkg::div_stat_t               stat_o,
  output logic [IDX_W-1:0]                 rem_o
);

  localparam int unsigned STEP_W = $clog2(tts_pkg::KEY_W);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [STEP_W-1:0]           cnt_q, cnt_d;
  logic [tts_pkg::KEY_W-1:0]   dvd_q, dvd_d;
  logic [CNT_W-1:0]            rem_q, rem_d;
  logic [CNT_W-1:0]            dsr_q, dsr_d;
  logic [CNT_W:0]              trial;

  // Shift in the next key bit, subtract when it fits
  assign trial = {rem_q, dvd_q[tts_pkg::KEY_W-1]};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i && !busy_q) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      dvd_d = {dvd_q[tts_pkg::KEY_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_q}) begin
        rem_d = CNT_W'(trial - {1'b0, dsr_q});
      end else begin
        rem_d = trial[CNT_W-1:0];
      end
      cnt_d = cnt_q + STEP_W'(1);
      if (cnt_q == STEP_W'(tts_pkg::KEY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dsr_q <= dsr_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign rem_o       = rem_q[IDX_W-1:0];

endmodule

`default_nettype wire

[design/tts_table_mem.sv]
// ----------------------------------------------------------------------------
// tts_table_mem
// Key and info memories: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tts_table_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned IDX_W = 12
) (
  input  wire logic                       clk_i,
  input  wire logic                       wr_en_i,
  input  wire logic [IDX_W-1:0]           wr_addr_i,
  input  wire logic [tts_pkg::KEY_W-1:0]  wr_key_i,
  input  wire tts_pkg::info_t             wr_info_i,
  input  wire logic                       rd_en_i,
  input  wire logic [IDX_W-1:0]           rd_addr_i,
  output logic [tts_pkg::KEY_W-1:0]       rd_key_o,
  output tts_pkg::info_t                  rd_info_o
);

  logic [tts_pkg::KEY_W-1:0] key_mem  [DEPTH];
  tts_pkg::info_t            info_mem [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      key_mem[wr_addr_i]  <= wr_key_i;
      info_mem[wr_addr_i] <= wr_info_i;
    end
  end

  // Read port, registered on rd_en_i
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_key_o  <= key_mem[rd_addr_i];
      rd_info_o <= info_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

[design/tts_checker.sv]
// ----------------------------------------------------------------------------
// tts_checker
// Port-level checks of the table store command handshake and result strobe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "transposition_table_store_core_macros.svh"

module tts_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic start_i,
  input wire logic busy_o,
  input wire logic res_valid_o
);

  // A taken item keeps the block busy in the next cycle
  `TTS_ASSERT_NEXT(a_accept_busy, start_i && !busy_o, busy_o)

  // No result in the cycle after an item is taken
  `TTS_ASSERT_NEXT(a_no_early_res, start_i && !busy_o, !res_valid_o)

  // A result strobe lasts one cycle
  `TTS_ASSERT_NEXT(a_res_pulse, res_valid_o, !res_valid_o)

  // A result comes only as the block turns idle after work
  `TTS_ASSERT_IMPL(a_res_at_finish, res_valid_o, !busy_o && $past(busy_o))

endmodule

bind transposition_table_store_core tts_checker u_tts_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start_i     (start_i),
  .busy_o      (busy_o),
  .res_valid_o (res_valid_o)
);

`default_nettype wire

[bench/transposition_table_store_core_test.sv]
// ----------------------------------------------------------------------------
// transposition_table_store_core_test
// Self-checking bench for the direct-mapped search-result table. It keeps its
// own copy of the table and the registers, predicts the answer of every find
// when the item is taken, and checks each strobed result against the oldest
// pending answer. Directed items cover empty slots, field extremes, every node
// code role, replacement and age mismatch. Random phases then run under
// several table sizes and code settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module transposition_table_store_core_test;

  localparam int unsigned TABLE_MAX       = 4096;
  localparam int unsigned DRAIN_CYCLES    = 80;
  localparam int unsigned CYCLE_LIMIT     = 1500000;
  localparam int unsigned PHASE_ITEMS     = 238;
  localparam int unsigned KEY_POOL_SIZE   = 24;
  localparam int unsigned REG_SPARE_FIRST = 5;
  localparam int unsigned REG_SPARE_LAST  = 7;

  typedef struct packed {
    logic [tts_pkg::CFG_IDX_W-1:0]  idx;
    logic [tts_pkg::CFG_DATA_W-1:0] data;
  } reg_write_t;

  // DUT ports
  logic                           clk_i       = 1'b0;
  logic                           rst_ni      = 1'b0;
  logic                           start_i     = 1'b0;
  tts_pkg::in_item_t              item_i      = '0;
  logic                           busy_o;
  logic                           res_valid_o;
  tts_pkg::res_item_t             res_o;
  logic                           cfg_valid_i = 1'b0;
  logic                           cfg_ready_o;
  logic [tts_pkg::CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [tts_pkg::CFG_DATA_W-1:0] cfg_data_i  = '0;

  // Table copy and register shadows
  logic [63:0]     slot_key [TABLE_MAX];
  tts_pkg::info_t  slot_info [TABLE_MAX];
  logic [12:0]     entries_reg   = 13'd256;
  logic [2:0]      exact_reg     = 3'd0;
  logic [2:0]      lower_reg     = 3'd1;
  logic [2:0]      upper_reg     = 3'd2;
  logic            old_moves_reg = 1'b0;

  tts_pkg::res_item_t find_answers_q [$];
  reg_write_t      reg_writes_q [$];
  logic [63:0]     key_pool [$];
  logic [14:0]     cur_age   = '0;
  bit              no_gaps   = 1'b0;
  int unsigned     err_cnt   = 0;
  int unsigned     cycle_cnt = 0;

  transposition_table_store_core #(
    .MAX_ENTRIES(TABLE_MAX)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_i),
    .item_i     (item_i),
    .busy_o     (busy_o),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("transposition_table_store_core test failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // Table model
  // ------------------------------------------------------------------------
  function automatic void clear_model();
    for (int i = 0; i < TABLE_MAX; i++) begin
      slot_key[i]  = '0;
      slot_info[i] = '0;
    end
  endfunction

  // Entry count clamped to what the table supports
  function automatic int unsigned slots_used();
    if (entries_reg < tts_pkg::MIN_ENTRIES) return tts_pkg::MIN_ENTRIES;
    if (entries_reg > TABLE_MAX) return TABLE_MAX;
    return int'(entries_reg);
  endfunction

  // Apply one taken item to the table copy; a find queues its answer
  function automatic void apply_to_table(tts_pkg::in_item_t it);
    logic [63:0]        slot64;
    logic [11:0]        slot;
    tts_pkg::info_t     s;
    tts_pkg::res_item_t ans;
    logic signed [15:0] sc;
    logic signed [15:0] al;
    logic signed [15:0] be;
    slot64 = it.hash_key % 64'(slots_used());
    slot   = slot64[11:0];
    s      = slot_info[slot];
    sc     = s.score;
    al     = it.alpha_in;
    be     = it.beta_in;
    if (it.op == tts_pkg::OP_PLACE) begin
      // an entry at least as new with a higher node code keeps its slot
      if (s.age >= it.search_age && s.node > it.node_code) return;
      slot_key[slot]        = it.hash_key;
      slot_info[slot].age   = it.search_age;
      slot_info[slot].move  = it.move_word;
      slot_info[slot].node  = it.node_code;
      slot_info[slot].depth = it.search_depth;
      slot_info[slot].score = it.entry_score;
      return;
    end
    ans           = '0;
    ans.alpha_out = al;
    ans.beta_out  = be;
    if (slot_key[slot] == it.hash_key) begin
      if (s.age == it.search_age) begin
        ans.hit_move = s.move;
        if (s.depth >= it.search_depth) begin
          // exact wins over lower bound, lower bound over upper bound
          if (s.node == exact_reg) begin
            ans.score_out = sc;
            ans.score_set = 1'b1;
          end else if (s.node == lower_reg) begin
            if (sc > al) ans.alpha_out = sc;
          end else if (s.node == upper_reg) begin
            if (sc < be) ans.beta_out = sc;
          end
        end
      end else if (old_moves_reg) begin
        ans.hit_move = s.move;
      end
    end
    find_answers_q.insert(find_answers_q.size(), ans);
  endfunction

  // ------------------------------------------------------------------------
  // Result checker
  // ------------------------------------------------------------------------
  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (want !== got) begin
      err_cnt++;
      $display("%0t: %s expected %h got %h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : check_results
    tts_pkg::res_item_t want;
    if (rst_ni && res_valid_o) begin
      if (find_answers_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no find pending, expected none got %h", $time, res_o);
      end else begin
        want = find_answers_q.pop_front();
        check_field("hit_move", want.hit_move, res_o.hit_move);
        check_field("score_out", want.score_out, res_o.score_out);
        check_field("score_set", 16'(want.score_set), 16'(res_o.score_set));
        check_field("alpha_out", want.alpha_out, res_o.alpha_out);
        check_field("beta_out", want.beta_out, res_o.beta_out);
      end
    end
  end

  // ------------------------------------------------------------------------
  // Drivers
  // ------------------------------------------------------------------------
  // Mostly back-to-back or short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 15);
    if (r < 8) return 0;
    if (r < 14) return $urandom_range(1, 4);
    return $urandom_range(5, 140);
  endfunction

  // Send one item, hold it until taken, then maybe idle
  task automatic issue_item(input tts_pkg::in_item_t it);
    int unsigned gap;
    start_i <= 1'b1;
    item_i  <= it;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    apply_to_table(it);
    gap = pick_gap();
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Wait until the block is idle: answers in, trailing place work done
  task automatic drain_table();
    start_i <= 1'b0;
    while (find_answers_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  function automatic void queue_write(logic [tts_pkg::CFG_IDX_W-1:0] idx,
                                      logic [tts_pkg::CFG_DATA_W-1:0] data);
    reg_write_t w;
    w.idx  = idx;
    w.data = data;
    reg_writes_q.insert(reg_writes_q.size(), w);
  endfunction

  // Push all queued register writes, valid held high across them
  task automatic flush_writes();
    reg_write_t w;
    while (reg_writes_q.size() != 0) begin
      w = reg_writes_q.pop_front();
      cfg_valid_i <= 1'b1;
      cfg_index_i <= w.idx;
      cfg_data_i  <= w.data;
      @(posedge clk_i);
      while (!cfg_ready_o) @(posedge clk_i);
      case (w.idx)
        tts_pkg::REG_TABLE_ENTRIES: begin
          entries_reg = w.data;
          clear_model();
        end
        tts_pkg::REG_EXACT_CODE:       exact_reg     = w.data[2:0];
        tts_pkg::REG_LOWER_BOUND_CODE: lower_reg     = w.data[2:0];
        tts_pkg::REG_UPPER_BOUND_CODE: upper_reg     = w.data[2:0];
        tts_pkg::REG_USE_OLD_MOVES:    old_moves_reg = w.data[0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  // ------------------------------------------------------------------------
  // Item builders
  // ------------------------------------------------------------------------
  function automatic tts_pkg::in_item_t noise_item();
    logic [159:0] raw;
    raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
    return raw[154:0];
  endfunction

  function automatic tts_pkg::in_item_t make_place(logic [63:0] key,
                                                   logic signed [15:0] score,
                                                   logic [7:0] depth, logic [2:0] node,
                                                   logic [15:0] move, logic [14:0] age);
    tts_pkg::in_item_t it;
    it              = noise_item();
    it.op           = tts_pkg::OP_PLACE;
    it.hash_key     = key;
    it.entry_score  = score;
    it.search_depth = depth;
    it.node_code    = node;
    it.move_word    = move;
    it.search_age   = age;
    return it;
  endfunction

  function automatic tts_pkg::in_item_t make_find(logic [63:0] key, logic [7:0] depth,
                                                  logic [14:0] age,
                                                  logic signed [15:0] alpha,
                                                  logic signed [15:0] beta);
    tts_pkg::in_item_t it;
    it              = noise_item();
    it.op           = tts_pkg::OP_FIND;
    it.hash_key     = key;
    it.search_depth = depth;
    it.search_age   = age;
    it.alpha_in     = alpha;
    it.beta_in      = beta;
    return it;
  endfunction

  // Keys mostly from a small pool so finds hit; some share a slot on purpose
  function automatic logic [63:0] pick_key();
    int unsigned r;
    logic [63:0] k;
    r = $urandom_range(0, 19);
    if (key_pool.size() == 0 || r < 3) begin
      k = (r == 0) ? 64'd0 : {$urandom, $urandom};
      if (key_pool.size() < KEY_POOL_SIZE) key_pool.insert(key_pool.size(), k);
      else key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)] = k;
      return k;
    end
    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (r < 6) k = k + 64'(slots_used()) * 64'($urandom_range(1, 3));
    return k;
  endfunction

  function automatic logic [14:0] pick_age();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 14) return cur_age;
    if (r < 16) return cur_age + 15'd1;
    if (r < 17) return cur_age - 15'd1;
    if (r < 19) return 15'($urandom_range(0, 32767));
    return '0;
  endfunction

  // Mostly well-formed places and finds on live keys, some pure noise
  function automatic tts_pkg::in_item_t random_item();
    tts_pkg::in_item_t it;
    int unsigned       r;
    it = noise_item();
    r  = $urandom_range(0, 99);
    if (r >= 90) return it;
    it.op         = (r < 40) ? tts_pkg::OP_PLACE : tts_pkg::OP_FIND;
    it.hash_key   = pick_key();
    it.search_age = pick_age();
    if (it.op == tts_pkg::OP_PLACE) begin
      case ($urandom_range(0, 3))
        0: it.node_code = exact_reg;
        1: it.node_code = lower_reg;
        2: it.node_code = upper_reg;
        default: ;
      endcase
    end else if ($urandom_range(0, 1) == 1) begin
      it.search_depth = 8'($urandom_range(0, 15));
    end
    return it;
  endfunction

  // ------------------------------------------------------------------------
  // Tests
  // ------------------------------------------------------------------------
  // Cleared slots hold key 0, age 0, node 0 and match like stored entries
  task automatic test_empty_slots();
    issue_item(make_find(64'd0, 8'd0, 15'd0, 16'sh8000, 16'sh7FFF));
    issue_item(make_find(64'd0, 8'd1, 15'd0, 16'sd0, 16'sd0));
    issue_item(make_find(64'd0, 8'd0, 15'd5, 16'sd7, -16'sd7));
    issue_item(make_find(64'd256, 8'd0, 15'd0, 16'sh7FFF, 16'sh8000));
  endtask

  // Field extremes and each node code role
  task automatic test_place_find();
    // exact entry with each other field at an extreme
    issue_item(make_place(64'hFFFF_FFFF_FFFF_FFFF, 16'sh8000, 8'd255, 3'd0,
                          16'hFFFF, 15'h7FFF));
    issue_item(make_find(64'hFFFF_FFFF_FFFF_FFFF, 8'd255, 15'h7FFF, 16'sd0, 16'sd0));
    // lower bound: raises a low alpha, leaves a high one
    issue_item(make_place(64'h8000_0000_0000_0001, 16'sh7FFF, 8'd8, 3'd1, 16'h0001, 15'd3));
    issue_item(make_find(64'h8000_0000_0000_0001, 8'd8, 15'd3, 16'sh8000, 16'sh7FFF));
    issue_item(make_find(64'h8000_0000_0000_0001, 8'd0, 15'd3, 16'sh7FFF, 16'sh7FFF));
    // upper bound lowers beta
    issue_item(make_place(64'h0123_4567_89AB_CDEF, -16'sd5, 8'd20, 3'd2, 16'h8000, 15'd3));
    issue_item(make_find(64'h0123_4567_89AB_CDEF, 8'd0, 15'd3, -16'sd100, 16'sh7FFF));
    // unknown code: move only
    issue_item(make_place(64'h0000_0000_0000_1010, 16'sd100, 8'd30, 3'd5, 16'h1234, 15'd3));
    issue_item(make_find(64'h0000_0000_0000_1010, 8'd0, 15'd3, 16'sd0, 16'sd0));
  endtask

  // Same slot, different keys: newer entries or ones coded at least as high replace
  task automatic test_replacement();
    issue_item(make_place(64'h55, 16'sd1, 8'd4, 3'd3, 16'hAAAA, 15'd10));
    issue_item(make_place(64'h155, 16'sd2, 8'd4, 3'd1, 16'hBBBB, 15'd10));
    issue_item(make_find(64'h55, 8'd0, 15'd10, 16'sd0, 16'sd0));
    issue_item(make_place(64'h155, 16'sd3, 8'd4, 3'd1, 16'hCCCC, 15'd11));
    issue_item(make_find(64'h155, 8'd0, 15'd11, 16'sd0, 16'sd0));
  endtask

  // Old moves on age mismatch; all three codes equal so exact wins
  task automatic test_old_moves_and_overlap();
    drain_table();
    queue_write(tts_pkg::REG_USE_OLD_MOVES, 13'h0001);
    queue_write(tts_pkg::REG_EXACT_CODE, 13'h1FFD);
    queue_write(tts_pkg::REG_LOWER_BOUND_CODE, 13'h0005);
    queue_write(tts_pkg::REG_UPPER_BOUND_CODE, 13'h0AAD);
    flush_writes();
    issue_item(make_find(64'h0000_0000_0000_1010, 8'd0, 15'd7, 16'sd0, 16'sd0));
    issue_item(make_find(64'h0000_0000_0000_1010, 8'd0, 15'd3, 16'sd0, 16'sd0));
    issue_item(make_find(64'h0000_0000_0000_1010, 8'd31, 15'd3, 16'sd0, 16'sd0));
  endtask

  // One random phase under a fresh table size and code setting
  task automatic test_random_phase(input logic [12:0] entries, input logic old_moves);
    drain_table();
    queue_write(tts_pkg::REG_TABLE_ENTRIES, entries);
    queue_write(tts_pkg::REG_EXACT_CODE, 13'($urandom_range(0, 8191)));
    queue_write(tts_pkg::REG_LOWER_BOUND_CODE, 13'($urandom_range(0, 8191)));
    queue_write(tts_pkg::REG_UPPER_BOUND_CODE, 13'($urandom_range(0, 8191)));
    queue_write(tts_pkg::REG_USE_OLD_MOVES, {12'($urandom_range(0, 4095)), old_moves});
    queue_write(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)),
                13'($urandom_range(0, 8191)));
    flush_writes();
    key_pool.delete();
    cur_age = 15'($urandom_range(0, 32767));
    for (int n = 0; n < PHASE_ITEMS; n++) begin
      // some stretches run with no idle cycles at all
      if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      issue_item(random_item());
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    clear_model();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_slots();
    test_place_find();
    test_replacement();
    test_old_moves_and_overlap();

    test_random_phase(13'd4096, 1'b0);
    test_random_phase(13'd100, 1'b1);
    test_random_phase(13'h1FFF, 1'($urandom_range(0, 1)));
    test_random_phase(13'd0, 1'b1);
    test_random_phase(13'd1000, 1'b0);
    test_random_phase(13'd256, 1'b1);

    drain_table();
    if (err_cnt == 0) begin
      $display("transposition_table_store_core test passed");
    end else begin
      $display("transposition_table_store_core test failed");
    end
    $finish;
  end

endmodule
